// File: src/assert_macros.svh
// Assertion macros shared by the bilinear scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bis_pkg.sv
// Shared constants, types and helpers of the bilinear image scaler.
`default_nettype none

package bis_pkg;

  // Frame memory geometry and fixed-point format.
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 12;

  // Field widths.
  localparam int COORD_W = 12;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int SIZE_W  = 10;
  localparam int SCALE_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Derived widths.
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int PROD_W    = COORD_W + SCALE_W;
  localparam int INT_W     = PROD_W - FRAC_BITS;
  localparam int CMP_W     = INT_W + 1;
  localparam int WF_W      = FRAC_BITS + 1;
  localparam int W_W       = 2 * FRAC_BITS + 1;
  localparam int ACC_W     = 2 * FRAC_BITS + CHAN_W + 2;

  localparam logic [WF_W-1:0]   ONE      = WF_W'(1) << FRAC_BITS;
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_WIDTH);

  // Commands.
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE = 2'd2;

  // Configuration reset values.
  localparam logic [SIZE_W-1:0]  RST_SOURCE_WIDTH  = 10'd512;
  localparam logic [SIZE_W-1:0]  RST_SOURCE_HEIGHT = 10'd512;
  localparam logic [SCALE_W-1:0] RST_INVERSE_SCALE = 16'd4096;

  // Neighbor order: upper left, upper right, lower left, lower right.
  localparam logic [1:0] NB_UL = 2'd0;
  localparam logic [1:0] NB_UR = 2'd1;
  localparam logic [1:0] NB_LL = 2'd2;
  localparam logic [1:0] NB_LR = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       store_en;
    logic       load_in;
    logic       mul;
    logic       wgt;
    logic       rd_en;
    logic [1:0] rd_idx;
    logic       mac_en;
    logic [1:0] mac_idx;
    logic       out_load;
  } bis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_image;
  } bis_status_t;

  // Frame memory address of a pixel, row-major.
  function automatic logic [ADDR_W-1:0] pix_addr(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
    pix_addr = ADDR_W'(y) * ROW_STEP + ADDR_W'(x);
  endfunction

endpackage

`default_nettype wire

// File: src/bis_ctrl.sv
// Controller state machine of the bilinear image scaler.
`default_nettype none

`include "assert_macros.svh"

module bis_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 command,
  output logic                out_valid,
  input  wire                 out_stall,
  input  bis_pkg::bis_status_t status,
  output bis_pkg::bis_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WGT,
    S_READ,
    S_LAST,
    S_DONE
  } state_t;

  state_t     state;
  logic [1:0] rd_cnt;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.store_en = in_valid && (command == bis_pkg::CMD_STORE);
        cmd.load_in  = in_valid && (command == bis_pkg::CMD_COMPUTE);
      end
      S_MUL: begin
        cmd.mul = 1'b1;
      end
      S_WGT: begin
        cmd.wgt = 1'b1;
      end
      S_READ: begin
        // Each pixel is weighted in the cycle after its read.
        cmd.rd_en   = 1'b1;
        cmd.rd_idx  = rd_cnt;
        cmd.mac_en  = (rd_cnt != bis_pkg::NB_UL);
        cmd.mac_idx = rd_cnt - 2'd1;
      end
      S_LAST: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_idx = bis_pkg::NB_LR;
      end
      S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_cnt    <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && (command == bis_pkg::CMD_COMPUTE)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_WGT;
        end
        S_WGT: begin
          rd_cnt <= 2'd0;
          state  <= status.in_image ? S_READ : S_DONE;
        end
        S_READ: begin
          rd_cnt <= rd_cnt + 2'd1;
          if (rd_cnt == bis_pkg::NB_LR) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BIS_ASSERT_IMP(a_result_from_done, $rose(out_valid), $past(state) == S_DONE, "result without finished transaction")
  `BIS_ASSERT_IMP(a_last_after_four, state == S_LAST, $past(state) == S_READ && $past(rd_cnt) == 2'd3, "last weighting step without four reads")
  `BIS_ASSERT_IMP(a_busy_no_store, state != S_IDLE, !cmd.store_en && !cmd.load_in, "transaction taken while busy")

endmodule

`default_nettype wire

// File: src/bis_datapath.sv
// Datapath of the bilinear image scaler: registers, frame memory and blend.
`default_nettype none

`include "assert_macros.svh"

module bis_datapath (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [bis_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [bis_pkg::CFG_W-1:0]             cfg_data,
  input  wire  [bis_pkg::COORD_W-1:0]           coord_x,
  input  wire  [bis_pkg::COORD_W-1:0]           coord_y,
  input  wire  [bis_pkg::CHAN_W-1:0]            in_red,
  input  wire  [bis_pkg::CHAN_W-1:0]            in_green,
  input  wire  [bis_pkg::CHAN_W-1:0]            in_blue,
  input  bis_pkg::bis_cmd_t                     cmd,
  output bis_pkg::bis_status_t                  status,
  output logic [bis_pkg::CHAN_W-1:0]            out_red,
  output logic [bis_pkg::CHAN_W-1:0]            out_green,
  output logic [bis_pkg::CHAN_W-1:0]            out_blue,
  output logic                                  inside_res
);

  localparam int F = bis_pkg::FRAC_BITS;

  // Configuration.
  logic [bis_pkg::SIZE_W-1:0]  src_width;
  logic [bis_pkg::SIZE_W-1:0]  src_height;
  logic [bis_pkg::SCALE_W-1:0] inv_scale;

  // Position arithmetic.
  logic [bis_pkg::COORD_W-1:0] cx_q;
  logic [bis_pkg::COORD_W-1:0] cy_q;
  logic [bis_pkg::PROD_W-1:0]  px;
  logic [bis_pkg::PROD_W-1:0]  py;
  logic [bis_pkg::INT_W-1:0]   x0;
  logic [bis_pkg::INT_W-1:0]   y0;
  logic [F-1:0]                frac_a;
  logic [F-1:0]                frac_b;
  logic [bis_pkg::WF_W-1:0]    one_a;
  logic [bis_pkg::WF_W-1:0]    one_b;
  logic [bis_pkg::CMP_W-1:0]   w_eff;
  logic [bis_pkg::CMP_W-1:0]   h_eff;
  logic                        in_image;
  logic                        inside_q;
  logic [bis_pkg::W_W-1:0]     wgt [4];
  logic [bis_pkg::ADDR_W-1:0]  base_addr;

  // Frame memory.
  logic [bis_pkg::PIX_W-1:0]   mem [bis_pkg::MEM_DEPTH];
  logic [bis_pkg::PIX_W-1:0]   rd_q;
  logic [bis_pkg::ADDR_W-1:0]  rd_addr;
  logic [bis_pkg::ADDR_W-1:0]  mem_addr;
  logic                        mem_we;
  logic                        store_in_range;

  // Per-channel accumulators.
  logic [bis_pkg::ACC_W-1:0]   acc_r;
  logic [bis_pkg::ACC_W-1:0]   acc_g;
  logic [bis_pkg::ACC_W-1:0]   acc_b;
  logic [bis_pkg::ACC_W-1:0]   mac_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bis_pkg::RST_SOURCE_WIDTH;
      src_height <= bis_pkg::RST_SOURCE_HEIGHT;
      inv_scale  <= bis_pkg::RST_INVERSE_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        bis_pkg::REG_SOURCE_WIDTH:  src_width  <= cfg_data[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_SOURCE_HEIGHT: src_height <= cfg_data[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_INVERSE_SCALE: inv_scale  <= cfg_data[bis_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Integer source position and fractions of the scaled coordinate.
  assign x0     = px[bis_pkg::PROD_W-1:F];
  assign y0     = py[bis_pkg::PROD_W-1:F];
  assign frac_a = px[F-1:0];
  assign frac_b = py[F-1:0];
  assign one_a  = bis_pkg::ONE - bis_pkg::WF_W'(frac_a);
  assign one_b  = bis_pkg::ONE - bis_pkg::WF_W'(frac_b);

  assign w_eff = (bis_pkg::CMP_W'(src_width) < bis_pkg::CMP_W'(bis_pkg::MAX_WIDTH)) ?
                 bis_pkg::CMP_W'(src_width) : bis_pkg::CMP_W'(bis_pkg::MAX_WIDTH);
  assign h_eff = (bis_pkg::CMP_W'(src_height) < bis_pkg::CMP_W'(bis_pkg::MAX_HEIGHT)) ?
                 bis_pkg::CMP_W'(src_height) : bis_pkg::CMP_W'(bis_pkg::MAX_HEIGHT);

  // The lower right neighbor must lie inside the effective source image.
  assign in_image = ((bis_pkg::CMP_W'(x0) + bis_pkg::CMP_W'(1)) < w_eff) &&
                    ((bis_pkg::CMP_W'(y0) + bis_pkg::CMP_W'(1)) < h_eff);
  assign status.in_image = in_image;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cx_q <= coord_x;
      cy_q <= coord_y;
    end
    if (cmd.mul) begin
      px <= bis_pkg::PROD_W'(cx_q) * bis_pkg::PROD_W'(inv_scale);
      py <= bis_pkg::PROD_W'(cy_q) * bis_pkg::PROD_W'(inv_scale);
    end
    if (cmd.wgt) begin
      inside_q  <= in_image;
      base_addr <= bis_pkg::pix_addr(x0[bis_pkg::XW-1:0], y0[bis_pkg::YW-1:0]);
      wgt[bis_pkg::NB_UL] <= bis_pkg::W_W'(one_a) * bis_pkg::W_W'(one_b);
      wgt[bis_pkg::NB_UR] <= bis_pkg::W_W'(frac_a) * bis_pkg::W_W'(one_b);
      wgt[bis_pkg::NB_LL] <= bis_pkg::W_W'(one_a) * bis_pkg::W_W'(frac_b);
      wgt[bis_pkg::NB_LR] <= bis_pkg::W_W'(frac_a) * bis_pkg::W_W'(frac_b);
    end
  end

  always_comb begin
    case (cmd.rd_idx)
      bis_pkg::NB_UL: rd_addr = base_addr;
      bis_pkg::NB_UR: rd_addr = base_addr + bis_pkg::ADDR_W'(1);
      bis_pkg::NB_LL: rd_addr = base_addr + bis_pkg::ROW_STEP;
      default:        rd_addr = base_addr + bis_pkg::ROW_STEP + bis_pkg::ADDR_W'(1);
    endcase
  end

  // Stores outside the frame memory are dropped.
  assign store_in_range =
    ({1'b0, coord_x} < (bis_pkg::COORD_W + 1)'(bis_pkg::MAX_WIDTH)) &&
    ({1'b0, coord_y} < (bis_pkg::COORD_W + 1)'(bis_pkg::MAX_HEIGHT));
  assign mem_we   = cmd.store_en && store_in_range;
  assign mem_addr = cmd.store_en ?
                    bis_pkg::pix_addr(coord_x[bis_pkg::XW-1:0], coord_y[bis_pkg::YW-1:0]) :
                    rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_red, in_green, in_blue};
    end
    if (cmd.rd_en) begin
      rd_q <= mem[mem_addr];
    end
  end

  // The first neighbor restarts the sums.
  assign mac_w = bis_pkg::ACC_W'(wgt[cmd.mac_idx]);

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc_r <= ((cmd.mac_idx == bis_pkg::NB_UL) ? '0 : acc_r) +
               mac_w * bis_pkg::ACC_W'(rd_q[3*bis_pkg::CHAN_W-1:2*bis_pkg::CHAN_W]);
      acc_g <= ((cmd.mac_idx == bis_pkg::NB_UL) ? '0 : acc_g) +
               mac_w * bis_pkg::ACC_W'(rd_q[2*bis_pkg::CHAN_W-1:bis_pkg::CHAN_W]);
      acc_b <= ((cmd.mac_idx == bis_pkg::NB_UL) ? '0 : acc_b) +
               mac_w * bis_pkg::ACC_W'(rd_q[bis_pkg::CHAN_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      inside_res <= inside_q;
      out_red    <= inside_q ? acc_r[2*F+bis_pkg::CHAN_W-1:2*F] : '0;
      out_green  <= inside_q ? acc_g[2*F+bis_pkg::CHAN_W-1:2*F] : '0;
      out_blue   <= inside_q ? acc_b[2*F+bis_pkg::CHAN_W-1:2*F] : '0;
    end
  end

  `BIS_ASSERT_IMP(a_port_exclusive, cmd.rd_en, !mem_we, "frame memory read and write in one cycle")
  `BIS_ASSERT_IMP(a_mac_after_read, cmd.mac_en, $past(cmd.rd_en), "weighting without read data")
  `BIS_ASSERT_NXT(a_outside_zero, cmd.out_load && !inside_q, out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && !inside_res, "outside result not zero")

endmodule

`default_nettype wire

// File: src/bilinear_image_scaler_core.sv
// Top level of the bilinear image scaler: controller and datapath.
//
//   Channel   Handshake                   Payload
//   input     in_valid / in_stall         command, coord_x, coord_y, in_red/green/blue
//   output    out_valid / out_stall       out_red, out_green, out_blue, inside_res
//   config    cfg_we                      cfg_index, cfg_data
//
// A store transaction writes the frame memory at acceptance. A compute transaction
// inside the image steps through multiply, weights, four reads of the single-port
// frame memory, last weighting step and output load; one whose lower right neighbor
// is off the image skips the reads and last weighting step. Reset is synchronous
// and sets the configuration registers; the frame memory is not cleared. A stalled
// result holds the block before its output load, while the input is not taken.
`default_nettype none

module bilinear_image_scaler_core (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire  [bis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [bis_pkg::CFG_W-1:0]         cfg_data,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               command,
  input  wire  [bis_pkg::COORD_W-1:0]       coord_x,
  input  wire  [bis_pkg::COORD_W-1:0]       coord_y,
  input  wire  [bis_pkg::CHAN_W-1:0]        in_red,
  input  wire  [bis_pkg::CHAN_W-1:0]        in_green,
  input  wire  [bis_pkg::CHAN_W-1:0]        in_blue,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [bis_pkg::CHAN_W-1:0]        out_red,
  output logic [bis_pkg::CHAN_W-1:0]        out_green,
  output logic [bis_pkg::CHAN_W-1:0]        out_blue,
  output logic                              inside_res
);

  bis_pkg::bis_cmd_t    cmd;
  bis_pkg::bis_status_t status;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bis_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .cmd        (cmd),
    .status     (status),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .inside_res (inside_res)
  );

endmodule

`default_nettype wire

// File: verif/tb_bilinear_image_scaler_core.sv
// Self-checking testbench of the bilinear image scaler core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_bilinear_image_scaler_core;
  import bis_pkg::*;

  localparam int     TARGET_ITEMS  = 1600;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     COORD_MAX     = (1 << COORD_W) - 1;
  localparam longint CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              in_image;
  } pixel_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // On a config row, x holds the register index and pix the register value.
  typedef struct packed {
    row_kind_t          kind;
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pix;
    logic               typed;
    pixel_res_t         res;
  } dir_row_t;

  localparam pixel_res_t OUTSIDE_RES = '0;

  localparam int DIR_ROWS = 33;
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM, CMD_STORE,   12'd0,    12'd0,    24'hFF0080, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd1,    12'd0,    24'h00FF7F, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd0,    12'd1,    24'h123456, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd1,    12'd1,    24'hFFFFFF, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd510,  12'd510,  24'h000000, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd511,  12'd510,  24'hFFFFFF, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd510,  12'd511,  24'h808080, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd511,  12'd511,  24'hAA5501, 1'b0, OUTSIDE_RES},
    // Stores beyond the frame memory are dropped; an aliased write to pixel (0, 0) would show up below.
    '{ROW_ITEM, CMD_STORE,   12'd4095, 12'd4095, 24'h5A5A5A, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd512,  12'd0,    24'hFFFFFF, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_STORE,   12'd0,    12'd512,  24'hFFFFFF, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd0,    12'd0,    24'h0, 1'b1, {24'hFF0080, 1'b1}},
    '{ROW_ITEM, CMD_COMPUTE, 12'd511,  12'd0,    24'h0, 1'b1, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd510,  12'd510,  24'h0, 1'b1, {24'h000000, 1'b1}},
    '{ROW_CFG,  CMD_STORE,   12'(REG_INVERSE_SCALE), 12'd0, 24'd2048, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd1,    12'd1,    24'h0, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd1021, 12'd1021, 24'h0, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd1022, 12'd0,    24'h0, 1'b1, OUTSIDE_RES},
    '{ROW_CFG,  CMD_STORE,   12'(REG_INVERSE_SCALE), 12'd0, 24'd0, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd4095, 12'd4095, 24'h0, 1'b1, {24'hFF0080, 1'b1}},
    '{ROW_CFG,  CMD_STORE,   12'(REG_INVERSE_SCALE), 12'd0, 24'd65535, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd0,    12'd0,    24'h0, 1'b1, {24'hFF0080, 1'b1}},
    '{ROW_ITEM, CMD_COMPUTE, 12'd4095, 12'd4095, 24'h0, 1'b1, OUTSIDE_RES},
    '{ROW_CFG,  CMD_STORE,   12'(REG_INVERSE_SCALE), 12'd0, 24'd1, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd4095, 12'd4095, 24'h0, 1'b0, OUTSIDE_RES},
    '{ROW_CFG,  CMD_STORE,   12'(REG_SOURCE_WIDTH), 12'd0, 24'd1, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd0,    12'd0,    24'h0, 1'b1, OUTSIDE_RES},
    '{ROW_CFG,  CMD_STORE,   12'(REG_SOURCE_WIDTH), 12'd0, 24'd0, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd0,    12'd0,    24'h0, 1'b1, OUTSIDE_RES},
    '{ROW_CFG,  CMD_STORE,   12'(REG_SOURCE_WIDTH), 12'd0, 24'd1023, 1'b0, OUTSIDE_RES},
    '{ROW_CFG,  CMD_STORE,   12'(REG_SOURCE_HEIGHT), 12'd0, 24'd2, 1'b0, OUTSIDE_RES},
    '{ROW_ITEM, CMD_COMPUTE, 12'd0,    12'd0,    24'h0, 1'b1, {24'hFF0080, 1'b1}},
    '{ROW_CFG,  CMD_STORE,   12'(REG_SOURCE_HEIGHT), 12'd0, 24'd1, 1'b0, OUTSIDE_RES}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 command = CMD_STORE;
  logic [COORD_W-1:0]   coord_x = '0;
  logic [COORD_W-1:0]   coord_y = '0;
  logic [CHAN_W-1:0]    in_red = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic                 inside_res;

  // Shadow of the frame memory and of the configuration registers.
  logic [PIX_W-1:0]   frame_copy [MEM_DEPTH];
  bit                 frame_written [MEM_DEPTH];
  logic [SIZE_W-1:0]  cur_width = RST_SOURCE_WIDTH;
  logic [SIZE_W-1:0]  cur_height = RST_SOURCE_HEIGHT;
  logic [SCALE_W-1:0] cur_inv_scale = RST_INVERSE_SCALE;

  pixel_res_t  color_due_q [$];
  int          errors = 0;
  int          burst_left = 0;
  longint      cycle_count = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  int unsigned rcv_cycle = 0;
  stall_mode_t stall_mode = STALL_NONE;

  bilinear_image_scaler_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .inside_res(inside_res)
  );

  always #2 clk = ~clk;

  // Maps a destination coordinate to its upper-left source pixel and fractions.
  function automatic bit map_position(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                      output longint unsigned x0, output longint unsigned y0,
                                      output longint unsigned a, output longint unsigned b);
    longint unsigned px, py, wd, ht;
    wd = (cur_width < MAX_WIDTH) ? cur_width : MAX_WIDTH;
    ht = (cur_height < MAX_HEIGHT) ? cur_height : MAX_HEIGHT;
    px = 64'(cx) * 64'(cur_inv_scale);
    py = 64'(cy) * 64'(cur_inv_scale);
    x0 = px >> FRAC_BITS;
    y0 = py >> FRAC_BITS;
    a  = px & ((64'd1 << FRAC_BITS) - 1);
    b  = py & ((64'd1 << FRAC_BITS) - 1);
    return (x0 + 1 < wd) && (y0 + 1 < ht);
  endfunction

  // True when a compute at this coordinate reads no pixel that was never stored.
  function automatic bit reads_written(input logic [COORD_W-1:0] cx,
                                       input logic [COORD_W-1:0] cy);
    longint unsigned x0, y0, a, b, base;
    if (!map_position(cx, cy, x0, y0, a, b)) return 1'b1;
    base = y0 * MAX_WIDTH + x0;
    return frame_written[base] && frame_written[base + 1] &&
           frame_written[base + MAX_WIDTH] && frame_written[base + MAX_WIDTH + 1];
  endfunction

  function automatic pixel_res_t bilinear_predict(input logic [COORD_W-1:0] cx,
                                                  input logic [COORD_W-1:0] cy);
    longint unsigned  x0, y0, a, b, base, unit, acc;
    logic [PIX_W-1:0] p00, p10, p01, p11;
    logic [CHAN_W-1:0] chan [3];
    unit = 64'd1 << FRAC_BITS;
    if (!map_position(cx, cy, x0, y0, a, b)) return OUTSIDE_RES;
    base = y0 * MAX_WIDTH + x0;
    p00 = frame_copy[base];
    p10 = frame_copy[base + 1];
    p01 = frame_copy[base + MAX_WIDTH];
    p11 = frame_copy[base + MAX_WIDTH + 1];
    // Red sits in the top byte, blue in the bottom one.
    for (int c = 0; c < 3; c++) begin
      acc = (unit - a) * (unit - b) * 64'(p00[(2 - c) * CHAN_W +: CHAN_W])
          + a * (unit - b) * 64'(p10[(2 - c) * CHAN_W +: CHAN_W])
          + (unit - a) * b * 64'(p01[(2 - c) * CHAN_W +: CHAN_W])
          + a * b * 64'(p11[(2 - c) * CHAN_W +: CHAN_W]);
      chan[c] = CHAN_W'(acc >> (2 * FRAC_BITS));
    end
    return '{chan[0], chan[1], chan[2], 1'b1};
  endfunction

  // Range of destination coordinates whose source position lands near a stored region.
  function automatic void dest_span(input int org, input int ext, input logic [SCALE_W-1:0] scl,
                                    output int lo, output int hi);
    if (scl == 0) begin
      lo = 0;
      hi = COORD_MAX;
    end else begin
      lo = int'((64'(org) << FRAC_BITS) / scl);
      hi = int'((64'(org + ext) << FRAC_BITS) / scl + 1);
      if (lo > COORD_MAX) lo = COORD_MAX;
      if (hi > COORD_MAX) hi = COORD_MAX;
    end
  endfunction

  // Offers one transaction, waits for it to be taken and records its effect.
  task automatic send_item(input logic cmd, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix,
                           input bit typed, input pixel_res_t typed_res);
    int gap;
    longint unsigned addr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command  <= cmd;
    coord_x  <= x;
    coord_y  <= y;
    in_red   <= pix[2 * CHAN_W +: CHAN_W];
    in_green <= pix[CHAN_W +: CHAN_W];
    in_blue  <= pix[0 +: CHAN_W];
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_STORE) begin
      if (x < MAX_WIDTH && y < MAX_HEIGHT) begin
        addr = 64'(y) * MAX_WIDTH + 64'(x);
        frame_copy[addr] = pix;
        frame_written[addr] = 1'b1;
      end
    end else if (typed) begin
      color_due_q.push_back(typed_res);
    end else begin
      color_due_q.push_back(bilinear_predict(x, y));
    end
  endtask

  // Stops offering and waits until every pending result is back and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (color_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SOURCE_WIDTH:  cur_width = val[SIZE_W-1:0];
      REG_SOURCE_HEIGHT: cur_height = val[SIZE_W-1:0];
      REG_INVERSE_SCALE: cur_inv_scale = val[SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pixel_res_t due;
    if (!rst && out_valid && !out_stall) begin
      if (color_due_q.size() == 0) begin
        $error("result transaction with none pending: red %0d green %0d blue %0d inside %0b",
               out_red, out_green, out_blue, inside_res);
        errors++;
      end else begin
        due = color_due_q.pop_front();
        check_field("out_red", due.red, out_red);
        check_field("out_green", due.green, out_green);
        check_field("out_blue", due.blue, out_blue);
        check_field("inside_res", CHAN_W'(due.in_image), CHAN_W'(inside_res));
      end
    end
  end

  always @(posedge clk) begin
    rcv_cycle <= rcv_cycle + 1;
    if (hold_go && !hold_done) begin
      // One long hold-off so that results back up into the input side.
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (rcv_cycle % 5) < 2;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bilinear_image_scaler_core: mismatch");
      $finish;
    end
  end

  initial begin
    int ox, oy, rw, rh, n_comp, done_items, phase, tries;
    int lo_x, hi_x, lo_y, hi_y;
    logic [SIZE_W-1:0]  wv, hv;
    logic [SCALE_W-1:0] sv;
    logic [COORD_W-1:0] cx, cy;
    done_items = 0;
    phase = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_tab[i].x[CFG_IDX_W-1:0], dir_tab[i].pix[CFG_W-1:0]);
      end else begin
        send_item(dir_tab[i].cmd, dir_tab[i].x, dir_tab[i].y, dir_tab[i].pix,
                  dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Each phase sets a new geometry and scale, stores a small source image, then
    // computes destination pixels whose neighbors are all stored.
    while (done_items < TARGET_ITEMS) begin
      ox = ($urandom_range(0, 3) == 0) ? $urandom_range(400, 490) : 0;
      oy = ($urandom_range(0, 3) == 0) ? $urandom_range(400, 490) : 0;
      rw = $urandom_range(2, 20);
      rh = $urandom_range(2, 20);
      case ($urandom_range(0, 7))
        0:       wv = SIZE_W'($urandom_range(0, 2));
        1:       wv = 10'd1023;
        2:       wv = 10'd512;
        3:       wv = SIZE_W'($urandom_range(0, 1023));
        default: wv = SIZE_W'(ox + rw);
      endcase
      case ($urandom_range(0, 7))
        0:       hv = SIZE_W'($urandom_range(0, 2));
        1:       hv = 10'd1023;
        2:       hv = 10'd512;
        3:       hv = SIZE_W'($urandom_range(0, 1023));
        default: hv = SIZE_W'(oy + rh);
      endcase
      case ($urandom_range(0, 9))
        0:       sv = 16'd0;
        1:       sv = 16'd1;
        2:       sv = 16'hFFFF;
        3:       sv = 16'd4096;
        4:       sv = SCALE_W'($urandom_range(1, 65535));
        5, 6:    sv = SCALE_W'($urandom_range(256, 4096));
        default: sv = SCALE_W'($urandom_range(4096, 12288));
      endcase

      drain();
      // Bits above the register width are don't-care; exercise them now and then.
      write_reg(REG_SOURCE_WIDTH, {($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom), wv});
      write_reg(REG_SOURCE_HEIGHT, {($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom), hv});
      write_reg(REG_INVERSE_SCALE, sv);

      for (int yy = 0; yy < rh; yy++) begin
        for (int xx = 0; xx < rw; xx++) begin
          if ($urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 1) == 0)
              send_item(CMD_STORE, COORD_W'($urandom_range(MAX_WIDTH, COORD_MAX)),
                        COORD_W'($urandom), PIX_W'($urandom), 1'b0, OUTSIDE_RES);
            else
              send_item(CMD_STORE, COORD_W'($urandom),
                        COORD_W'($urandom_range(MAX_HEIGHT, COORD_MAX)),
                        PIX_W'($urandom), 1'b0, OUTSIDE_RES);
          end
          send_item(CMD_STORE, COORD_W'(ox + xx), COORD_W'(oy + yy), PIX_W'($urandom),
                    1'b0, OUTSIDE_RES);
          done_items++;
        end
      end

      dest_span(ox, rw, sv, lo_x, hi_x);
      dest_span(oy, rh, sv, lo_y, hi_y);
      n_comp = $urandom_range(100, 220);
      for (int k = 0; k < n_comp; k++) begin
        if (phase == 1 && k == 0) hold_go <= 1'b1;
        tries = 0;
        do begin
          cx = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom_range(0, COORD_MAX))
                                           : COORD_W'($urandom_range(lo_x, hi_x));
          cy = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom_range(0, COORD_MAX))
                                           : COORD_W'($urandom_range(lo_y, hi_y));
          tries++;
        end while (!reads_written(cx, cy) && tries < 20);
        // Occasional stores into the region keep the memory changing between computes.
        if (reads_written(cx, cy) && $urandom_range(0, 9) != 0)
          send_item(CMD_COMPUTE, cx, cy, PIX_W'($urandom), 1'b0, OUTSIDE_RES);
        else
          send_item(CMD_STORE, COORD_W'(ox + $urandom_range(0, rw - 1)),
                    COORD_W'(oy + $urandom_range(0, rh - 1)), PIX_W'($urandom),
                    1'b0, OUTSIDE_RES);
        done_items++;
      end
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("bilinear_image_scaler_core: match");
    end else begin
      $display("bilinear_image_scaler_core: mismatch");
    end
    $finish;
  end

endmodule

// File: bilinear_image_scaler_core.f
+incdir+src
src/bis_pkg.sv
src/bis_ctrl.sv
src/bis_datapath.sv
src/bilinear_image_scaler_core.sv
verif/tb_bilinear_image_scaler_core.sv
